// ===== rtl/fanuart_pkg.sv =====
// Shared constants and types for the fan UART frame receiver.
package fanuart_pkg;

  localparam int FRAME_BYTES = 6;
  localparam int BYTE_CNT_W  = 3;
  localparam int TIMEOUT_W   = 10;
  localparam int BUF_DEPTH   = FRAME_BYTES - 1;

  localparam logic [7:0]           START_MARK    = 8'h01;
  localparam logic [7:0]           TYPE_RESPONSE = 8'hF3;
  localparam logic [7:0]           VALUE_FAILED  = 8'hA0;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(50);

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FAILED   = 3'd1,
    ST_OTHER    = 3'd2,
    ST_CHECKSUM = 3'd3,
    ST_HEADER   = 3'd4
  } status_t;

  typedef struct packed {
    logic       valid;
    status_t    status;
    logic [7:0] frame_type;
    logic [7:0] aux_byte;
    logic [7:0] value_byte;
  } frame_res_t;

endpackage

// ===== rtl/fanuart_frame.sv =====
// Frame assembly state, idle timer and frame classification.
module fanuart_frame import fanuart_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic                 is_tick,
  input  logic [7:0]           rx_byte,
  input  logic [TIMEOUT_W-1:0] timeout,
  output frame_res_t           res
);

  logic [7:0]            frame_r [BUF_DEPTH];
  logic [BYTE_CNT_W-1:0] byte_cnt_r, byte_cnt_nxt;
  logic [TIMEOUT_W-1:0]  idle_r, idle_nxt;
  logic                  keep;
  logic [TIMEOUT_W:0]    idle_inc;
  logic [7:0]            sum;

  assign idle_inc = {1'b0, idle_r} + (TIMEOUT_W+1)'(1);
  assign sum      = frame_r[1] + frame_r[2] + frame_r[4];

  always_comb begin
    byte_cnt_nxt = byte_cnt_r;
    idle_nxt     = idle_r;
    keep         = 1'b0;
    res          = '0;
    res.status   = ST_OK;
    if (is_tick) begin
      if (idle_inc > {1'b0, timeout}) begin
        byte_cnt_nxt = '0;
        idle_nxt     = '0;
      end else begin
        idle_nxt = idle_inc[TIMEOUT_W-1:0];
      end
    end else if (byte_cnt_r == '0) begin
      keep         = 1'b1;
      byte_cnt_nxt = BYTE_CNT_W'(1);
      idle_nxt     = '0;
    end else if (frame_r[0] != START_MARK) begin
      // Bad start mark: drop both bytes, timer keeps running.
      byte_cnt_nxt = '0;
      res.valid    = 1'b1;
      res.status   = ST_HEADER;
    end else if (byte_cnt_r < BYTE_CNT_W'(BUF_DEPTH)) begin
      keep         = 1'b1;
      byte_cnt_nxt = byte_cnt_r + BYTE_CNT_W'(1);
      idle_nxt     = '0;
    end else begin
      // Last byte completes the frame; it is not stored and the timer is left alone.
      byte_cnt_nxt   = '0;
      res.valid      = 1'b1;
      res.frame_type = frame_r[1];
      res.aux_byte   = frame_r[2];
      res.value_byte = frame_r[4];
      priority if (sum != frame_r[3]) begin
        res.status = ST_CHECKSUM;
      end else if (frame_r[1] == TYPE_RESPONSE) begin
        res.status = (frame_r[4] == VALUE_FAILED) ? ST_FAILED : ST_OK;
      end else begin
        res.status = ST_OTHER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_cnt_r <= '0;
      idle_r     <= '0;
    end else if (step) begin
      byte_cnt_r <= byte_cnt_nxt;
      idle_r     <= idle_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && keep) begin
      frame_r[byte_cnt_r] <= rx_byte;
    end
  end

endmodule

// ===== rtl/fan_uart_frame_receiver_top.sv =====
// Top level of the fan UART frame receiver: input register, frame logic, result register.
//
// Each input transaction is either a millisecond tick or one received byte; the block
// assembles six-byte frames and reports one result per completed frame or bad start
// mark. It takes one transaction every clock cycle; each one passes from the input
// register through the single stage of frame logic into the result register, which
// drives out_tvalid. Backpressure on the result side stalls the input side only once
// both registers are full. The idle timeout register is written through cfg_wr_en and
// should be changed only while the block is idle.
module fan_uart_frame_receiver_top import fanuart_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,    // [7:0] rx_byte
  input  logic                 in_tuser,    // [0] is_tick
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [23:0]          out_tdata,   // [7:0] frame_type, [15:8] aux_byte, [23:16] value_byte
  output logic [2:0]           out_tuser,   // [2:0] status
  input  logic                 cfg_wr_en,
  input  logic [TIMEOUT_W-1:0] cfg_wr_data  // idle_timeout_ticks
);

  logic                 in_valid_r;
  logic [7:0]           in_byte_r;
  logic                 in_tick_r;
  logic [TIMEOUT_W-1:0] timeout_r;
  logic                 out_valid_r;
  logic [23:0]          out_data_r;
  status_t              out_status_r;
  logic                 step;
  frame_res_t           res;

  assign step      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || step;

  fanuart_frame u_frame (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .is_tick (in_tick_r),
    .rx_byte (in_byte_r),
    .timeout (timeout_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      timeout_r   <= TIMEOUT_RESET;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (step) begin
        out_valid_r <= res.valid;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        timeout_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_tick_r <= in_tuser;
    end
    if (step && res.valid) begin
      out_data_r   <= {res.value_byte, res.aux_byte, res.frame_type};
      out_status_r <= res.status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

endmodule

// ===== rtl/fanuart_checker.sv =====
// Port-level checks on the result channel of the frame receiver, bound to the top level.
module fanuart_checker import fanuart_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [2:0]  out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= ST_HEADER)
    else $error("status code out of range");

  a_header_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_HEADER |-> out_tdata == '0)
    else $error("header error carries nonzero fields");

  a_response_type: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_OK || out_tuser == ST_FAILED)
      |-> out_tdata[7:0] == TYPE_RESPONSE)
    else $error("response status without response type");

  a_failed_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_FAILED |-> out_tdata[23:16] == VALUE_FAILED)
    else $error("failed status without failure value");

endmodule

bind fan_uart_frame_receiver_top fanuart_checker u_fanuart_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== tb/sv/tb_fan_uart_frame_receiver_top.sv =====
// Self-checking testbench for the fan UART frame receiver with a built-in frame predictor.
module tb_fan_uart_frame_receiver_top;
  import fanuart_pkg::*;

  localparam int QUIET_LIMIT = 4000;

  typedef struct packed {
    logic       is_tick;
    logic [7:0] rx_byte;
  } serial_item_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] frame_type;
    logic [7:0] aux_byte;
    logic [7:0] value_byte;
  } frame_report_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata = '0;
  logic                 in_tuser = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [23:0]          out_tdata;
  logic [2:0]           out_tuser;
  logic                 cfg_wr_en = 1'b0;
  logic [TIMEOUT_W-1:0] cfg_wr_data = '0;

  // Predictor state.
  logic [7:0]           frame_buf [BUF_DEPTH];
  logic [2:0]           byte_cnt = '0;
  logic [TIMEOUT_W-1:0] idle_cnt = '0;
  logic [TIMEOUT_W-1:0] timeout_cfg = TIMEOUT_RESET;

  serial_item_t  pending_items [$];
  frame_report_t expected_reports [$];

  int unsigned items_queued = 0;
  int unsigned items_accepted = 0;
  int unsigned reports_seen = 0;
  int unsigned status_seen [5] = '{default: 0};
  int unsigned error_cnt = 0;
  int unsigned settings_used = 1;
  int unsigned quiet_cycles = 0;

  // Traffic shaping, set per phase by the stimulus process.
  bit          sender_bursty = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  logic [15:0] stall_pattern = 16'hFFFF;
  logic [3:0]  stall_phase = '0;

  fan_uart_frame_receiver_top i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #5 clk = ~clk;

  function automatic void note_mismatch(string what);
    error_cnt++;
    if (error_cnt <= 10) $display("ERROR at %0t: %s", $realtime, what);
  endfunction

  // Advances the frame tracker by one accepted transaction.
  function automatic void track_frame(logic is_tick, logic [7:0] rx);
    frame_report_t rep;
    logic [7:0]    sum;
    if (is_tick) begin
      if (idle_cnt + 11'd1 > {1'b0, timeout_cfg}) begin
        byte_cnt = '0;
        idle_cnt = '0;
      end else begin
        idle_cnt = idle_cnt + 1'b1;
      end
    end else if (byte_cnt == 0) begin
      frame_buf[0] = rx;
      byte_cnt = 3'd1;
      idle_cnt = '0;
    end else if (frame_buf[0] != START_MARK) begin
      // A bad start mark drops both bytes and leaves the timer running.
      byte_cnt = '0;
      rep = '{ST_HEADER, 8'h00, 8'h00, 8'h00};
      expected_reports = {expected_reports, rep};
    end else if (byte_cnt < BUF_DEPTH) begin
      frame_buf[byte_cnt] = rx;
      byte_cnt = byte_cnt + 1'b1;
      idle_cnt = '0;
    end else begin
      byte_cnt = '0;
      sum = frame_buf[1] + frame_buf[2] + frame_buf[4];
      rep.frame_type = frame_buf[1];
      rep.aux_byte   = frame_buf[2];
      rep.value_byte = frame_buf[4];
      if (sum != frame_buf[3]) rep.status = ST_CHECKSUM;
      else if (frame_buf[1] != TYPE_RESPONSE) rep.status = ST_OTHER;
      else if (frame_buf[4] == VALUE_FAILED) rep.status = ST_FAILED;
      else rep.status = ST_OK;
      expected_reports = {expected_reports, rep};
    end
  endfunction

  // Input driver: presents queued transactions, in bursts separated by idle gaps when the sender is bursty.
  always @(posedge clk) begin
    serial_item_t next_item;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        track_frame(in_tuser, in_tdata);
        items_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          next_item = pending_items.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= next_item.rx_byte;
          in_tuser  <= next_item.is_tick;
          if (sender_bursty) begin
            if (burst_left <= 1) begin
              burst_left = $urandom_range(1, 12);
              gap_left   = $urandom_range(1, 5);
            end else begin
              burst_left--;
            end
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares every result transaction with the oldest expected report.
  always @(posedge clk) begin
    frame_report_t want;
    frame_report_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{status_t'(out_tuser), out_tdata[7:0], out_tdata[15:8], out_tdata[23:16]};
      reports_seen++;
      if (out_tuser < 3'd5) status_seen[out_tuser]++;
      if (expected_reports.size() == 0) begin
        note_mismatch($sformatf("unexpected result status %0d type %02h aux %02h value %02h",
                                out_tuser, got.frame_type, got.aux_byte, got.value_byte));
      end else begin
        want = expected_reports.pop_front();
        if (got != want)
          note_mismatch($sformatf(
            "expected status %0d type %02h aux %02h value %02h, got %0d %02h %02h %02h",
            want.status, want.frame_type, want.aux_byte, want.value_byte,
            out_tuser, got.frame_type, got.aux_byte, got.value_byte));
      end
    end
    out_tready  <= stall_pattern[stall_phase];
    stall_phase <= stall_phase + 1'b1;
  end

  // The watchdog ends the run when no transaction moves for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (rst_n) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("watchdog expired with %0d reports outstanding", expected_reports.size());
        $display("fan_uart_frame_receiver_top regression: fail");
        $finish;
      end
    end
  end

  task automatic push_item(logic is_tick, logic [7:0] rx);
    serial_item_t it;
    it.is_tick = is_tick;
    it.rx_byte = rx;
    pending_items = {pending_items, it};
    items_queued++;
  endtask

  task automatic push_ticks(int unsigned n);
    repeat (n) push_item(1'b1, 8'($urandom_range(0, 255)));
  endtask

  // Queues a frame with an optional fixed number of ticks between its bytes.
  task automatic push_frame(logic [7:0] ftype, logic [7:0] aux, logic [7:0] value,
                            logic [7:0] sum_flip, int unsigned tick_gap);
    logic [7:0] bytes [FRAME_BYTES];
    bytes = '{START_MARK, ftype, aux, (ftype + aux + value) ^ sum_flip, value,
              8'($urandom_range(0, 255))};
    for (int i = 0; i < FRAME_BYTES; i++) begin
      push_item(1'b0, bytes[i]);
      if (i < FRAME_BYTES - 1) push_ticks(tick_gap);
    end
  endtask

  // Mostly well-formed frames with random content, the rest broken frames and noise.
  task automatic push_random_traffic(int unsigned n);
    int unsigned target;
    int unsigned pick;
    int unsigned reach;
    logic [7:0]  ftype;
    logic [7:0]  value;
    logic [7:0]  first;
    target = items_queued + n;
    reach = (timeout_cfg <= 30) ? timeout_cfg + 2 : 4;
    while (items_queued < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        ftype = ($urandom_range(0, 1) == 0) ? TYPE_RESPONSE : 8'($urandom_range(0, 255));
        value = ($urandom_range(0, 2) == 0) ? VALUE_FAILED : 8'($urandom_range(0, 255));
        push_frame(ftype, 8'($urandom_range(0, 255)), value,
                   ($urandom_range(0, 6) == 0) ? 8'($urandom_range(1, 255)) : 8'h00,
                   ($urandom_range(0, 4) == 0) ? $urandom_range(1, reach) : 0);
      end else if (pick < 75) begin
        do first = 8'($urandom_range(0, 255)); while (first == START_MARK);
        push_item(1'b0, first);
        repeat ($urandom_range(1, 5)) push_item(1'b0, 8'($urandom_range(0, 255)));
      end else if (pick < 87) begin
        push_item(1'b0, START_MARK);
        repeat ($urandom_range(0, 4)) push_item(1'b0, 8'($urandom_range(0, 255)));
        if (timeout_cfg <= 40) push_ticks(timeout_cfg + $urandom_range(0, 2));
      end else if (pick < 94) begin
        push_ticks($urandom_range(1, reach));
      end else begin
        push_item(1'b0, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Waits until every queued transaction is taken and every report has come back.
  task automatic wait_drained(int unsigned tail_cycles);
    while (items_accepted != items_queued || expected_reports.size() != 0) @(posedge clk);
    repeat (tail_cycles) @(posedge clk);
  endtask

  task automatic set_traffic(bit bursty, bit stalls);
    sender_bursty = bursty;
    burst_left = 0;
    stall_pattern = stalls ? (16'($urandom_range(0, 16'hFFFF)) | 16'h0001) : 16'hFFFF;
  endtask

  task automatic write_timeout(logic [TIMEOUT_W-1:0] ticks);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= ticks;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    timeout_cfg = ticks;
    settings_used++;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset timeout: one frame of each kind and a bad start mark.
    set_traffic(1'b1, 1'b1);
    push_frame(TYPE_RESPONSE, 8'h12, 8'h34, 8'h00, 0);
    push_frame(TYPE_RESPONSE, 8'h00, VALUE_FAILED, 8'h00, 0);
    push_frame(8'hFF, 8'hFF, 8'hFF, 8'h00, 0);
    push_frame(8'h00, 8'h00, 8'h00, 8'h01, 0);
    push_item(1'b0, 8'h00);
    push_item(1'b0, 8'hFF);
    push_random_traffic(150);
    wait_drained(8);

    // Shortest timeout: a tick after each kept byte is fine, two in a row drop the frame.
    write_timeout(10'd1);
    set_traffic(1'b0, 1'b0);
    push_frame(TYPE_RESPONSE, 8'h5A, 8'h77, 8'h00, 1);
    push_item(1'b0, START_MARK);
    push_ticks(2);
    push_frame(8'h3C, 8'hC3, 8'h81, 8'h00, 0);
    push_random_traffic(150);
    wait_drained(8);

    // Longest timeout: a partial frame survives a long idle stretch.
    write_timeout(10'd1023);
    set_traffic(1'b1, 1'b0);
    push_item(1'b0, START_MARK);
    push_item(1'b0, TYPE_RESPONSE);
    push_ticks(100);
    push_item(1'b0, 8'h20);
    push_item(1'b0, 8'(TYPE_RESPONSE + 8'h20 + 8'h45));
    push_item(1'b0, 8'h45);
    push_item(1'b0, 8'hEE);
    push_frame(TYPE_RESPONSE, 8'h01, VALUE_FAILED, 8'h00, 0);
    push_random_traffic(100);
    wait_drained(8);

    write_timeout(TIMEOUT_W'($urandom_range(2, 8)));
    set_traffic(1'b1, 1'b1);
    push_random_traffic(150);
    wait_drained(8);

    write_timeout(TIMEOUT_W'($urandom_range(1, 1023)));
    set_traffic(1'b0, 1'b1);
    push_random_traffic(150);
    wait_drained(8);

    write_timeout(TIMEOUT_W'($urandom_range(9, 40)));
    set_traffic(1'b1, 1'b0);
    push_random_traffic(150);
    wait_drained(8);

    write_timeout(TIMEOUT_RESET);
    set_traffic(1'b1, 1'b1);
    push_random_traffic(100);
    wait_drained(10);

    if (expected_reports.size() != 0)
      note_mismatch($sformatf("%0d reports never arrived", expected_reports.size()));
    $display("%0d serial transactions over %0d timeout settings, %0d frame reports checked",
             items_accepted, settings_used, reports_seen);
    $display("reports: ok %0d, failed %0d, other %0d, checksum %0d, header %0d; errors %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4],
             error_cnt);
    if (error_cnt == 0) begin
      $display("fan_uart_frame_receiver_top regression: pass");
    end else begin
      $display("fan_uart_frame_receiver_top regression: fail");
    end
    $finish;
  end

endmodule
